>>> sv/abt_pkg.sv
`timescale 1ns / 1ps
package abt_pkg;

  localparam int CoordW   = 32;
  localparam int CoefW    = 16;
  localparam int RowW     = 3 * CoefW;
  localparam int ProdW    = CoordW + CoefW;
  localparam int FracW    = 12;
  localparam int TermW    = ProdW - FracW;
  localparam int SumW     = TermW + 2;
  localparam int Axes     = 3;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam int BoxW     = 2 * Axes * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [RowW-1:0]   row_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // stage advance enables, shared by all axis slices
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  localparam logic [2:0] REG_ROW_X   = 3'd0;
  localparam logic [2:0] REG_ROW_Y   = 3'd1;
  localparam logic [2:0] REG_ROW_Z   = 3'd2;
  localparam logic [2:0] REG_SHIFT_X = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z = 3'd5;

  localparam row_t ROW_X_RESET = 48'h0000_0000_1000;
  localparam row_t ROW_Y_RESET = 48'h0000_1000_0000;
  localparam row_t ROW_Z_RESET = 48'h1000_0000_0000;

endpackage

>>> sv/abt_axis.sv
`timescale 1ns / 1ps
module abt_axis (
  input  logic                            clk,
  input  abt_pkg::adv_t                   adv,
  input  abt_pkg::coord_t [2:0]           lo,
  input  abt_pkg::coord_t [2:0]           hi,
  input  abt_pkg::row_t                   coef,
  input  abt_pkg::coord_t                 shift,
  output abt_pkg::coord_t                 min_o,
  output abt_pkg::coord_t                 max_o
);
  import abt_pkg::*;

  localparam sum_t SatHi = sum_t'(coord_t'({1'b0, {(CoordW-1){1'b1}}}));
  localparam sum_t SatLo = sum_t'(coord_t'({1'b1, {(CoordW-1){1'b0}}}));

  logic signed [ProdW-1:0] prod_lo [3];
  logic signed [ProdW-1:0] prod_hi [3];
  logic signed [CoefW-1:0] c       [3];
  term_t a_r  [3];
  term_t b_r  [3];
  term_t mn_nxt [3];
  term_t mx_nxt [3];
  term_t mn_r [3];
  term_t mx_r [3];
  sum_t  sum_mn;
  sum_t  sum_mx;
  coord_t min_r;
  coord_t max_r;

  function automatic coord_t sat(input sum_t v);
    coord_t r;
    if (v > SatHi) begin
      r = coord_t'(SatHi);
    end else if (v < SatLo) begin
      r = coord_t'(SatLo);
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  // stage 1: exact products, floor by dropping fraction bits
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c[j]       = coef[CoefW*j +: CoefW];
      prod_lo[j] = $signed(lo[j]) * c[j];
      prod_hi[j] = $signed(hi[j]) * c[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      for (int j = 0; j < 3; j++) begin
        a_r[j] <= prod_lo[j][ProdW-1:FracW];
        b_r[j] <= prod_hi[j][ProdW-1:FracW];
      end
    end
  end

  // stage 2: order each pair
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (a_r[j] < b_r[j]) begin
        mn_nxt[j] = a_r[j];
        mx_nxt[j] = b_r[j];
      end else begin
        mn_nxt[j] = b_r[j];
        mx_nxt[j] = a_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int j = 0; j < 3; j++) begin
        mn_r[j] <= mn_nxt[j];
        mx_r[j] <= mx_nxt[j];
      end
    end
  end

  // stage 3: accumulate, translate, saturate
  always_comb begin
    sum_mn = sum_t'(mn_r[0]) + sum_t'(mn_r[1]) + sum_t'(mn_r[2]) + sum_t'(shift);
    sum_mx = sum_t'(mx_r[0]) + sum_t'(mx_r[1]) + sum_t'(mx_r[2]) + sum_t'(shift);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      min_r <= sat(sum_mn);
      max_r <= sat(sum_mx);
    end
  end

  assign min_o = min_r;
  assign max_o = max_r;

endmodule

>>> sv/affine_box_transform.sv
`timescale 1ns / 1ps
// channel  | dir | signals                          | payload
// in_      | in  | in_tvalid/in_tready/in_tdata     | box corners, 6 x Q16.16
// out_     | out | out_tvalid/out_tready/out_tdata  | bounding box, 6 x Q16.16
// cfg_     | in  | APB, 64-bit data, regs at 8*i    | 3 coef rows, 3 translations
//
// Three register stages: multiply, min/max select, sum and saturate.
// One box per cycle while out_tready is high; an in transfer loads stage 1, and
// out_tvalid rises once the box has passed through stage 2 into stage 3.
// out_tready reaches in_tready combinationally; a full stage holds only while
// the next one holds, so bubbles are filled while stalled.
// rst_n clears stage valids and loads the identity transform.
module affine_box_transform (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  input  logic [abt_pkg::BoxW-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  output logic [abt_pkg::BoxW-1:0]       out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [abt_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [abt_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [abt_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import abt_pkg::*;

  row_t   row_r   [3];
  coord_t shift_r [3];
  logic   v1_r, v2_r, v3_r;
  logic   v1_nxt, v2_nxt, v3_nxt;
  adv_t   adv;
  logic   cfg_wr;
  logic [2:0] cfg_idx;
  coord_t [2:0] lo;
  coord_t [2:0] hi;
  coord_t min_o [3];
  coord_t max_o [3];

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CfgAddrW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= ROW_X_RESET;
      row_r[1]   <= ROW_Y_RESET;
      row_r[2]   <= ROW_Z_RESET;
      shift_r[0] <= '0;
      shift_r[1] <= '0;
      shift_r[2] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW_X:   row_r[0]   <= cfg_pwdata[RowW-1:0];
        REG_ROW_Y:   row_r[1]   <= cfg_pwdata[RowW-1:0];
        REG_ROW_Z:   row_r[2]   <= cfg_pwdata[RowW-1:0];
        REG_SHIFT_X: shift_r[0] <= cfg_pwdata[CoordW-1:0];
        REG_SHIFT_Y: shift_r[1] <= cfg_pwdata[CoordW-1:0];
        REG_SHIFT_Z: shift_r[2] <= cfg_pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW_X:   cfg_prdata = CfgDataW'(row_r[0]);
      REG_ROW_Y:   cfg_prdata = CfgDataW'(row_r[1]);
      REG_ROW_Z:   cfg_prdata = CfgDataW'(row_r[2]);
      REG_SHIFT_X: cfg_prdata = CfgDataW'(unsigned'(shift_r[0]));
      REG_SHIFT_Y: cfg_prdata = CfgDataW'(unsigned'(shift_r[1]));
      REG_SHIFT_Z: cfg_prdata = CfgDataW'(unsigned'(shift_r[2]));
      default:     cfg_prdata = '0;
    endcase
  end

  // a stage loads when empty or when its contents move on
  assign adv.s3    = !v3_r || out_tready;
  assign adv.s2    = !v2_r || adv.s3;
  assign adv.s1    = !v1_r || adv.s2;
  assign in_tready = adv.s1;

  assign v1_nxt = adv.s1 ? in_tvalid : v1_r;
  assign v2_nxt = adv.s2 ? v1_r      : v2_r;
  assign v3_nxt = adv.s3 ? v2_r      : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign out_tvalid = v3_r;

  for (genvar j = 0; j < Axes; j++) begin : g_unpack
    assign lo[j] = in_tdata[CoordW*j +: CoordW];
    assign hi[j] = in_tdata[CoordW*(Axes+j) +: CoordW];
  end

  for (genvar i = 0; i < Axes; i++) begin : g_axis
    abt_axis u_axis (
      .clk   (clk),
      .adv   (adv),
      .lo    (lo),
      .hi    (hi),
      .coef  (row_r[i]),
      .shift (shift_r[i]),
      .min_o (min_o[i]),
      .max_o (max_o[i])
    );
    assign out_tdata[CoordW*i +: CoordW]        = min_o[i];
    assign out_tdata[CoordW*(Axes+i) +: CoordW] = max_o[i];
  end

  // back-pressure only when every stage is full
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a bubble in the pipeline");

  // a held stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv.s2) |=> v1_r)
    else $error("stage 1 item lost while stalled");

  a_s2_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv.s3) |=> v3_r)
    else $error("stage 2 item dropped on advance");

  // sums of ordered terms stay ordered through saturation
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((min_o[0] <= max_o[0]) && (min_o[1] <= max_o[1]) &&
                    (min_o[2] <= max_o[2])))
    else $error("output box minimum above maximum");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import abt_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_BOXES = 115;

  typedef struct packed {
    coord_t max_z;
    coord_t max_y;
    coord_t max_x;
    coord_t min_z;
    coord_t min_y;
    coord_t min_x;
  } box_t;

  typedef enum int {SET_IDENTITY, SET_POS_EXT, SET_NEG_EXT, SET_TINY, SET_RANDOM} setting_t;

  typedef struct {
    setting_t set;
    box_t     b;
    bit       has_exp;
    box_t     exp_box;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  logic [BoxW-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // min_x, min_y, min_z, max_x, max_y, max_z (32 bits each)
  logic [BoxW-1:0]     out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  affine_box_transform uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  row_t       coef_row [3];
  coord_t     shift_amt [3];
  box_t       expected_boxes [$];
  dir_row_t   dir_tab [$];
  setting_t   cur_set;
  bit         quiet = 1'b0;
  int         mismatches = 0;
  int         results_checked = 0;
  int         boxes_sent = 0;
  int         settings_applied = 0;
  int         stall_cnt = 0;
  box_t       got_box;
  box_t       want_box;
  string      field_names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

  function automatic coord_t sat_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return coord_t'(v);
  endfunction

  function automatic box_t transform_box(input box_t b);
    coord_t lo [3];
    coord_t hi [3];
    coord_t res_lo [3];
    coord_t res_hi [3];
    logic signed [CoefW-1:0] c;
    longint acc_lo, acc_hi, pa, pb;
    box_t r;
    lo = '{b.min_x, b.min_y, b.min_z};
    hi = '{b.max_x, b.max_y, b.max_z};
    for (int i = 0; i < Axes; i++) begin
      acc_lo = 0;
      acc_hi = 0;
      for (int j = 0; j < Axes; j++) begin
        c = coef_row[i][CoefW*j +: CoefW];
        pa = (longint'(lo[j]) * longint'(c)) >>> FracW;
        pb = (longint'(hi[j]) * longint'(c)) >>> FracW;
        if (pa < pb) begin
          acc_lo += pa;
          acc_hi += pb;
        end else begin
          acc_lo += pb;
          acc_hi += pa;
        end
      end
      acc_lo += longint'(shift_amt[i]);
      acc_hi += longint'(shift_amt[i]);
      res_lo[i] = sat_q16(acc_lo);
      res_hi[i] = sat_q16(acc_hi);
    end
    r.min_x = res_lo[0];
    r.min_y = res_lo[1];
    r.min_z = res_lo[2];
    r.max_x = res_hi[0];
    r.max_y = res_hi[1];
    r.max_z = res_hi[2];
    return r;
  endfunction

  function automatic box_t mk_box(input logic [31:0] nx, ny, nz, xx, xy, xz);
    box_t r;
    r.min_x = nx;
    r.min_y = ny;
    r.min_z = nz;
    r.max_x = xx;
    r.max_y = xy;
    r.max_z = xz;
    return r;
  endfunction

  function automatic void add_row(input setting_t s, input box_t b, input bit has_exp,
                                  input box_t e);
    dir_row_t row;
    row.set = s;
    row.b = b;
    row.has_exp = has_exp;
    row.exp_box = e;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h1000;
      4: return 16'hF000;
      5, 6, 7: return 16'($urandom_range(0, 16'h4000) - 16'h2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
      3: return 32'($urandom_range(0, 8) - 4);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic box_t rand_box();
    coord_t a [3];
    coord_t b [3];
    coord_t t;
    box_t r;
    for (int j = 0; j < Axes; j++) begin
      a[j] = rand_coord();
      b[j] = ($urandom_range(99) < 5) ? a[j] : rand_coord();
      // mostly well-formed boxes, some left inverted
      if ($urandom_range(99) < 85 && a[j] > b[j]) begin
        t = a[j];
        a[j] = b[j];
        b[j] = t;
      end
    end
    r = mk_box(a[0], a[1], a[2], b[0], b[1], b[2]);
    return r;
  endfunction

  function automatic int pick_gap();
    int g;
    g = 0;
    if (!quiet)
      while ($urandom_range(99) < 25) g++;
    return g;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      REG_ROW_X:   coef_row[0] = val[RowW-1:0];
      REG_ROW_Y:   coef_row[1] = val[RowW-1:0];
      REG_ROW_Z:   coef_row[2] = val[RowW-1:0];
      REG_SHIFT_X: shift_amt[0] = val[CoordW-1:0];
      REG_SHIFT_Y: shift_amt[1] = val[CoordW-1:0];
      REG_SHIFT_Z: shift_amt[2] = val[CoordW-1:0];
      default: ;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic cfg_write(input logic [2:0] idx, input logic [CfgDataW-1:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CfgAddrW'({idx, 3'b000});
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    store_reg(idx, val);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    row_t r [3];
    coord_t sh [3];
    logic [2:0] row_regs [3];
    logic [2:0] shift_regs [3];
    row_regs = '{REG_ROW_X, REG_ROW_Y, REG_ROW_Z};
    shift_regs = '{REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z};
    for (int k = 0; k < Axes; k++) begin
      case (s)
        SET_IDENTITY: begin
          r[k] = (k == 0) ? ROW_X_RESET : (k == 1) ? ROW_Y_RESET : ROW_Z_RESET;
          sh[k] = '0;
        end
        SET_POS_EXT: begin
          r[k] = {3{16'h7FFF}};
          sh[k] = 32'h7FFF_FFFF;
        end
        SET_NEG_EXT: begin
          r[k] = {3{16'h8000}};
          sh[k] = 32'h8000_0000;
        end
        SET_TINY: begin
          r[k] = {3{16'h0001}};
          sh[k] = '0;
        end
        default: begin
          r[k] = {rand_coef(), rand_coef(), rand_coef()};
          sh[k] = rand_coord();
        end
      endcase
    end
    for (int k = 0; k < Axes; k++) begin
      cfg_write(row_regs[k], {16'($urandom), r[k]});
      cfg_write(shift_regs[k], {32'($urandom), sh[k]});
    end
    // writes past the register list must leave everything alone
    cfg_write(REG_SPARE_A, {32'($urandom), 32'($urandom)});
    cfg_write(REG_SPARE_B, {32'($urandom), 32'($urandom)});
    cur_set = s;
    settings_applied++;
  endtask

  // entered and left at a falling edge
  task automatic send_box(input box_t b, input bit has_exp, input box_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    expected_boxes.push_back(has_exp ? e : transform_box(b));
    boxes_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_box = out_tdata;
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result transfer with nothing expected: %h", got_box);
      end else begin
        want_box = expected_boxes.pop_front();
        results_checked++;
        for (int k = 0; k < 6; k++) begin
          if (got_box[CoordW*k +: CoordW] !== want_box[CoordW*k +: CoordW]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d %s expected %h got %h", results_checked,
                       field_names[k], want_box[CoordW*k +: CoordW],
                       got_box[CoordW*k +: CoordW]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    coef_row = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
    shift_amt = '{32'h0, 32'h0, 32'h0};
    cur_set = SET_IDENTITY;

    add_row(SET_IDENTITY, mk_box(0, 0, 0, 0, 0, 0), 1, mk_box(0, 0, 0, 0, 0, 0));
    add_row(SET_IDENTITY,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(SET_IDENTITY,
            mk_box(32'h0001_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                   32'hFFFF_0000, 32'h8000_0000, 32'hEDCB_A988), 1,
            mk_box(32'hFFFF_0000, 32'h8000_0000, 32'hEDCB_A988,
                   32'h0001_0000, 32'h7FFF_FFFF, 32'h1234_5678));
    add_row(SET_IDENTITY,
            mk_box(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h5555_5555, 32'h5555_5555), 1,
            mk_box(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h5555_5555, 32'h5555_5555));
    add_row(SET_IDENTITY,
            mk_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1), 1,
            mk_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1));
    add_row(SET_IDENTITY, rand_box(), 0, '0);
    add_row(SET_TINY,
            mk_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1), 1,
            mk_box(32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD, 0, 0, 0));
    add_row(SET_TINY,
            mk_box(32'h0FFF, 32'h0FFF, 32'h0FFF, 32'h1000, 32'h1000, 32'h1000), 1,
            mk_box(0, 0, 0, 3, 3, 3));
    // inverted, negative, rounding down
    add_row(SET_TINY,
            mk_box(32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_F000,
                   32'hFFFF_EFFF, 32'hFFFF_EFFF, 32'hFFFF_EFFF), 1,
            mk_box(32'hFFFF_FFFA, 32'hFFFF_FFFA, 32'hFFFF_FFFA,
                   32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFD));
    add_row(SET_POS_EXT,
            mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1,
            mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(SET_POS_EXT,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_row(SET_POS_EXT, mk_box(0, 0, 0, 0, 0, 0), 1,
            mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(SET_POS_EXT,
            mk_box(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000,
                   32'h0001_0000, 32'h0002_0000, 32'h0003_0000), 0, '0);
    add_row(SET_NEG_EXT,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(SET_NEG_EXT, mk_box(0, 0, 0, 0, 0, 0), 1,
            mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_row(SET_NEG_EXT,
            mk_box(32'h0000_8000, 32'hFFFF_8000, 32'h0010_0000,
                   32'h0001_8000, 32'h0000_8000, 32'h0020_0000), 0, '0);
    add_row(SET_RANDOM, rand_box(), 0, '0);
    add_row(SET_RANDOM, rand_box(), 0, '0);
    add_row(SET_RANDOM, mk_box(32'h8000_0000, 0, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 0, 32'h8000_0000), 0, '0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].set != cur_set) begin
        drain();
        apply_setting(dir_tab[k].set);
      end
      send_box(dir_tab[k].b, dir_tab[k].has_exp, dir_tab[k].exp_box);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      quiet = (p == 3);
      case (p)
        0: apply_setting(SET_IDENTITY);
        5: apply_setting(SET_POS_EXT);
        9: apply_setting(SET_NEG_EXT);
        default: apply_setting(SET_RANDOM);
      endcase
      for (int n = 0; n < PHASE_BOXES; n++)
        send_box(rand_box(), 0, '0);
    end
    quiet = 1'b0;
    drain();

    $display("Summary: %0d boxes in, %0d result boxes compared, %0d register settings",
             boxes_sent, results_checked, settings_applied);
    $display("Directed extremes, saturation, rounding and inverted boxes, then random boxes");
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
